// ===== rtl/wmda_pkg.sv =====
package wmda_pkg;

  // Register file layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THR  = 2'd2;

  // Field widths fixed by the register map and result format
  localparam int WLEN_W   = 7;
  localparam int THR_W    = 17;
  localparam int METRIC_W = 17;

  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd16;
  localparam logic [THR_W-1:0]  THR_RST  = 17'h1FFFF;

  // Divider status towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/wmda_if.sv =====
// Sample channel
interface wmda_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result channel
interface wmda_out_if import wmda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                warning;
  logic                alarm;
  logic [METRIC_W-1:0] metric;

  modport source (output valid, output warning, output alarm, output metric, input ready);
  modport sink   (input valid, input warning, input alarm, input metric, output ready);
endinterface

// ===== rtl/window_mean_deviation_alarm.sv =====
// Flow: after a sample transfer, a read pass over the sample RAM sums the last n samples
//   (n being the effective window length) and a bit-serial division yields the mean; a second
//   pass and division yield the mean absolute deviation; the result then goes to the output
//   register. The next sample is taken only once the result is in the output register, so an
//   output stall holds off new samples.
// Reset (synchronous, rst_n low): ring treated as all zeros via a fill count, write pointer 0,
//   window_len 16, both thresholds 131071, no result pending.
module window_mean_deviation_alarm import wmda_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wmda_in_if.sink               in_ch,
  wmda_out_if.source            out_ch
);

  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int CLG_W  = $clog2(WINDOW_MAX + 1);
  localparam int LEN_W  = (CLG_W > WLEN_W) ? CLG_W : WLEN_W;
  localparam int SUM_W  = SAMPLE_BITS + CLG_W;
  localparam int MX_W   = (SAMPLE_BITS + 1 > METRIC_W) ? SAMPLE_BITS + 1 : METRIC_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_DEV  = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // Configuration
  logic [WLEN_W-1:0] window_len_r;
  logic [THR_W-1:0]  warn_thr_r;
  logic [THR_W-1:0]  alarm_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WLEN_RST;
      warn_thr_r   <= THR_RST;
      alarm_thr_r  <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WINDOW_LEN: window_len_r <= cfg_wdata[WLEN_W-1:0];
        CFG_WARN_THR:   warn_thr_r   <= cfg_wdata[THR_W-1:0];
        CFG_ALARM_THR:  alarm_thr_r  <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and datapath state
  logic [2:0]             state_r;
  logic [ADDR_W-1:0]      wp_r;
  logic [ADDR_W-1:0]      wp_nxt;
  logic [LEN_W-1:0]       fill_r;
  logic [ADDR_W-1:0]      newest_r;
  logic [ADDR_W-1:0]      rd_ptr_r;
  logic [ADDR_W-1:0]      rd_ptr_nxt;
  logic [LEN_W-1:0]       n_r;
  logic [LEN_W-1:0]       n_nxt;
  logic [LEN_W-1:0]       issue_k_r;
  logic                   pend_r;
  logic                   pend_ok_r;
  logic [SUM_W-1:0]       acc_r;
  logic [SAMPLE_BITS-1:0] mean_r;
  logic [SAMPLE_BITS-1:0] dev_r;
  logic                   out_valid_r;
  logic                   warning_r;
  logic                   alarm_r;
  logic [METRIC_W-1:0]    metric_r;

  logic                   in_xfer;
  logic                   in_pass;
  logic                   issue;
  logic                   pass_done;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] absdiff;
  logic [SUM_W-1:0]       add_val;
  logic [SAMPLE_BITS:0]   md_sum;
  logic [MX_W-1:0]        md_wide;
  logic [METRIC_W-1:0]    metric_nxt;
  logic [LEN_W-1:0]       wlen_ext;

  div_stat_t              div_st;
  logic                   div_start;
  logic [SUM_W-1:0]       div_quo;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Ring pointers wrap at the window depth
  assign wp_nxt     = (wp_r == ADDR_W'(WINDOW_MAX - 1)) ? '0 : wp_r + ADDR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == '0) ? ADDR_W'(WINDOW_MAX - 1) : rd_ptr_r - ADDR_W'(1);

  // Effective window length: zero reads as one, saturate at the ring depth
  always_comb begin
    wlen_ext = LEN_W'(window_len_r);
    if (wlen_ext == '0) begin
      n_nxt = LEN_W'(1);
    end else if (wlen_ext > LEN_W'(WINDOW_MAX)) begin
      n_nxt = LEN_W'(WINDOW_MAX);
    end else begin
      n_nxt = wlen_ext;
    end
  end

  // Pass sequencing: one read issued per cycle, data arriving in the cycle after its read
  assign in_pass   = (state_r == ST_SUM) || (state_r == ST_DEV);
  assign issue     = in_pass && (issue_k_r < n_r);
  assign pass_done = in_pass && !issue && !pend_r;
  assign div_start = pass_done;

  // Entries never written since reset read as zero
  assign smp     = pend_ok_r ? rd_data : '0;
  assign absdiff = (smp >= mean_r) ? smp - mean_r : mean_r - smp;
  assign add_val = (state_r == ST_SUM) ? SUM_W'(smp) : SUM_W'(absdiff);

  // Metric and output load
  assign md_sum     = {1'b0, mean_r} + {1'b0, dev_r};
  assign md_wide    = MX_W'(md_sum);
  assign metric_nxt = md_wide[METRIC_W-1:0];
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      pend_ok_r   <= 1'b0;
      issue_k_r   <= '0;
      n_r         <= LEN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      // Output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // Read pipeline tracking
      if (in_pass) begin
        pend_r    <= issue;
        pend_ok_r <= issue_k_r < fill_r;
        if (issue) begin
          rd_ptr_r  <= rd_ptr_nxt;
          issue_k_r <= issue_k_r + LEN_W'(1);
        end
        if (pend_r) begin
          acc_r <= acc_r + add_val;
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            wp_r      <= wp_nxt;
            fill_r    <= (fill_r == LEN_W'(WINDOW_MAX)) ? fill_r : fill_r + LEN_W'(1);
            newest_r  <= wp_r;
            rd_ptr_r  <= wp_r;
            n_r       <= n_nxt;
            issue_k_r <= '0;
            acc_r     <= '0;
            state_r   <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (pass_done) begin
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_st.done) begin
            mean_r    <= div_quo[SAMPLE_BITS-1:0];
            rd_ptr_r  <= newest_r;
            issue_k_r <= '0;
            acc_r     <= '0;
            state_r   <= ST_DEV;
          end
        end
        ST_DEV: begin
          if (pass_done) begin
            state_r <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_st.done) begin
            dev_r   <= div_quo[SAMPLE_BITS-1:0];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            warning_r <= metric_nxt >= warn_thr_r;
            alarm_r   <= metric_nxt >= alarm_thr_r;
            metric_r  <= metric_nxt;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample ring
  wmda_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wp_r),
    .wdata (in_ch.sample),
    .re    (issue),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  // Shared divider for the mean and the deviation
  wmda_div #(
    .DVD_W (SUM_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (n_r),
    .stat     (div_st),
    .quotient (div_quo)
  );

  assign out_ch.valid   = out_valid_r;
  assign out_ch.warning = warning_r;
  assign out_ch.alarm   = alarm_r;
  assign out_ch.metric  = metric_r;

  // Checks
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(WINDOW_MAX))
    else $error("fill count beyond ring depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (n_r != '0) && (n_r <= LEN_W'(WINDOW_MAX)) && (issue_k_r <= n_r))
    else $error("window length or read count out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_DIV1) || (state_r == ST_DIV2))
    else $error("divider finished outside a divide state");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result presented without a completed computation");

endmodule

// ===== rtl/wmda_ram.sv =====
// Simple dual-port RAM, one write and one registered read port
module wmda_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wmda_div.sv =====
// Restoring divider, one quotient bit per cycle
module wmda_div import wmda_pkg::*; #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import wmda_pkg::*;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 30;
  localparam int THR_MAX      = 131071;

  // index with no register behind it; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct {
    logic                warning;
    logic                alarm;
    logic [METRIC_W-1:0] metric;
  } alarm_result_t;

  typedef enum int {SMP_FULL, SMP_CLUSTER, SMP_EXTREME, SMP_LOW} sample_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wmda_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  wmda_out_if out_ch ();

  window_mean_deviation_alarm #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predictor state: sample history and register copies
  logic [SAMPLE_BITS-1:0] ring_model [WINDOW_MAX];
  logic [5:0]             ring_wr_ptr;
  logic [WLEN_W-1:0]      win_len_reg;
  logic [THR_W-1:0]       warn_thr_reg;
  logic [THR_W-1:0]       alarm_thr_reg;

  alarm_result_t pending_alarms [$];

  int fail_count;
  int items_sent;
  int results_seen;
  int warnings_seen;
  int alarms_seen;
  int phases_run;
  int stuck_cycles;
  int stall_left;
  bit src_quiet;
  bit sink_quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // push the sample into the history and work out mean + mean abs deviation
  function automatic alarm_result_t predict_alarm(input logic [SAMPLE_BITS-1:0] value);
    alarm_result_t res;
    int unsigned   n;
    int unsigned   total;
    int unsigned   mean;
    int unsigned   abs_sum;
    int unsigned   s;
    int unsigned   sum_metric;
    int            k;
    logic [5:0]    slot;
    ring_model[ring_wr_ptr] = value;
    ring_wr_ptr = ring_wr_ptr + 6'd1;
    n = win_len_reg;
    if (n == 0) n = 1;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    total = 0;
    for (k = 0; k < n; k++) begin
      slot = ring_wr_ptr - 6'd1 - k[5:0];
      total += ring_model[slot];
    end
    mean = total / n;
    abs_sum = 0;
    for (k = 0; k < n; k++) begin
      slot = ring_wr_ptr - 6'd1 - k[5:0];
      s = ring_model[slot];
      abs_sum += (s >= mean) ? (s - mean) : (mean - s);
    end
    sum_metric = mean + abs_sum / n;
    res.metric  = sum_metric[METRIC_W-1:0];
    res.warning = (res.metric >= warn_thr_reg);
    res.alarm   = (res.metric >= alarm_thr_reg);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < MAX_REPORTS)
      $display("[%0t] mismatch: %s got %0d want %0d (result %0d)", $time, what, got, want,
               results_seen);
    fail_count++;
  endtask

  // block until every predicted result has been consumed
  task automatic wait_drain();
    while (pending_alarms.size() != 0) @(negedge clk);
  endtask

  // register write while the block is idle; predictor copy follows
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drain();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WINDOW_LEN: win_len_reg   = data[WLEN_W-1:0];
      CFG_WARN_THR:   warn_thr_reg  = data[THR_W-1:0];
      CFG_ALARM_THR:  alarm_thr_reg = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // one sample transfer; expectation queued at acceptance
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    repeat (gap) @(negedge clk);
    in_ch.sample = value;
    in_ch.valid  = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_alarms.push_back(predict_alarm(value));
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // result sink back-pressure
  always @(negedge clk) begin
    if (stall_left == 0 && !sink_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin : chk
    alarm_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.warning) warnings_seen++;
      if (out_ch.alarm) alarms_seen++;
      if (pending_alarms.size() == 0) begin
        report_mismatch("unexpected result, metric", out_ch.metric, 0);
      end else begin
        want = pending_alarms.pop_front();
        if (out_ch.metric !== want.metric) report_mismatch("metric", out_ch.metric, want.metric);
        if (out_ch.warning !== want.warning)
          report_mismatch("warning", out_ch.warning, want.warning);
        if (out_ch.alarm !== want.alarm) report_mismatch("alarm", out_ch.alarm, want.alarm);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 stuck_cycles, pending_alarms.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // reset defaults: zeros from reset sit in the window, thresholds unreachable
  task automatic test_early_samples();
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h8000);
    send_sample(16'h0000);
  endtask

  // window length of zero, one, full and beyond full (upper data bits ignored)
  task automatic test_window_bounds();
    write_reg(CFG_WINDOW_LEN, 17'd0);
    send_sample(16'hFFFF);
    send_sample(16'h1234);
    write_reg(CFG_WINDOW_LEN, 17'd127);
    send_sample(16'h7FFF);
    send_sample(16'hFFFF);
    write_reg(CFG_WINDOW_LEN, 17'd1);
    send_sample(16'hAAAA);
    write_reg(CFG_WINDOW_LEN, 17'd64);
    send_sample(16'h5555);
    send_sample(16'h0000);
    write_reg(CFG_WINDOW_LEN, 17'h1FFC1);
    send_sample(16'hFFFF);
  endtask

  // flags at zero threshold, exactly at threshold and one below
  task automatic test_thresholds();
    write_reg(CFG_WINDOW_LEN, 17'd1);
    write_reg(CFG_WARN_THR, 17'd0);
    write_reg(CFG_ALARM_THR, 17'h1FFFF);
    send_sample(16'h0000);
    write_reg(CFG_WARN_THR, 17'h00100);
    write_reg(CFG_ALARM_THR, 17'h00101);
    send_sample(16'h0100);
    send_sample(16'h0101);
    send_sample(16'h00FF);
    write_reg(CFG_WINDOW_LEN, 17'd2);
    write_reg(CFG_ALARM_THR, 17'd0);
    send_sample(16'hFFFF);
  endtask

  // write to the unused index must leave all registers alone
  task automatic test_unused_index();
    write_reg(CFG_IDX_SPARE, 17'd0);
    send_sample(16'h0040);
    send_sample(16'hC000);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] gen_sample(input sample_mode_t mode,
                                                        input int level, input int spread);
    int v;
    case (mode)
      SMP_FULL:    v = int'($urandom_range(0, 65535));
      SMP_CLUSTER: v = level + int'($urandom_range(0, 2 * spread)) - spread;
      SMP_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = 0;
          1:       v = 1;
          2:       v = 65534;
          default: v = 65535;
        endcase
      end
      default:     v = int'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // threshold near the expected metric most of the time so flags toggle
  function automatic logic [THR_W-1:0] pick_threshold(input int base, input int spread);
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 10) t = 0;
    else if (r < 20) t = THR_MAX;
    else if (r < 35) t = int'($urandom_range(0, THR_MAX));
    else t = base + int'($urandom_range(0, spread + 1));
    if (t > THR_MAX) t = THR_MAX;
    return t[THR_W-1:0];
  endfunction

  // phases of random configuration followed by random samples
  task automatic test_random_phases();
    int           target;
    int           count;
    int           r;
    int           level;
    int           spread;
    int           wlen;
    logic [THR_W-1:0] warn_thr;
    sample_mode_t mode;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      phases_run++;
      r = $urandom_range(0, 99);
      if (r < 8) wlen = 0;
      else if (r < 45) wlen = $urandom_range(1, 8);
      else if (r < 85) wlen = $urandom_range(9, 63);
      else if (r < 92) wlen = WINDOW_MAX;
      else wlen = $urandom_range(65, 127);
      case ($urandom_range(0, 3))
        0: begin mode = SMP_FULL;    level = 32768; spread = 32768; end
        1: begin mode = SMP_CLUSTER; level = $urandom_range(0, 65535);
                 spread = $urandom_range(0, 4096); end
        2: begin mode = SMP_EXTREME; level = 32768; spread = 32768; end
        default: begin mode = SMP_LOW; level = 128; spread = 128; end
      endcase
      write_reg(CFG_WINDOW_LEN, (CFG_DATA_W'($urandom) & 17'h1FF80) | CFG_DATA_W'(wlen));
      warn_thr = pick_threshold(level, spread);
      write_reg(CFG_WARN_THR, warn_thr);
      write_reg(CFG_ALARM_THR, pick_threshold(int'(warn_thr), spread));
      src_quiet  = ($urandom_range(0, 4) == 0);
      sink_quiet = ($urandom_range(0, 4) == 0);
      count = $urandom_range(20, 60);
      repeat (count) send_sample(gen_sample(mode, level, spread));
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_WINDOW_LEN;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    src_quiet    = 1'b0;
    sink_quiet   = 1'b0;
    fail_count   = 0;
    items_sent   = 0;
    results_seen = 0;
    warnings_seen = 0;
    alarms_seen  = 0;
    phases_run   = 0;
    stuck_cycles = 0;
    foreach (ring_model[i]) ring_model[i] = '0;
    ring_wr_ptr   = '0;
    win_len_reg   = WLEN_RST;
    warn_thr_reg  = THR_RST;
    alarm_thr_reg = THR_RST;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_early_samples();
    test_window_bounds();
    test_thresholds();
    test_unused_index();
    test_random_phases();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d samples over %0d random phases, %0d results checked",
             items_sent, phases_run, results_seen);
    $display("warning raised %0d times, alarm raised %0d times, %0d mismatches",
             warnings_seen, alarms_seen, fail_count);
    if (fail_count == 0 && pending_alarms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
